@@ rtl/fbdr_pkg.sv @@
// shared widths, limits and control bundles for the flat-bottom distance restraint
package fbdr_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = 33;
    localparam int ABS_W      = 33;
    localparam int LEN_W      = 31;
    localparam int K_W        = 32;
    localparam int SUM_W      = 66;
    localparam int DIST_W     = 33;
    localparam int MAG_W      = 33;
    localparam int MUL_A_W    = 66;
    localparam int MUL_B_W    = 33;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int NUM_W      = 98;
    localparam int QUO_W      = 48;
    localparam int ENERGY_W   = 64;
    localparam int FORCE_W    = 48;
    localparam int NUM_AXES   = 3;

    localparam int LN_LSB     = 2 * NUM_AXES * COORD_W;
    localparam int TOL_LSB    = LN_LSB + LEN_W;
    localparam int K_LSB      = TOL_LSB + LEN_W;
    localparam int IN_BITS    = K_LSB + K_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 2 * ENERGY_W + NUM_AXES * FORCE_W;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX    = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0]  FORCE_POS_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0]  FORCE_NEG_MAX = {1'b1, {(FORCE_W-1){1'b0}}};

    typedef struct packed {
        logic start;
        logic root;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_rsp;

endpackage

@@ rtl/fbdr_mul.sv @@
// iterative multiplier, one 8-bit digit of the second operand per cycle
module fbdr_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [fbdr_pkg::MUL_A_W-1:0]     i_a,
    input  logic [fbdr_pkg::MUL_B_W-1:0]     i_b,
    output logic                             o_done,
    output logic [fbdr_pkg::PROD_W-1:0]      o_prod
);

    localparam int DIG_W  = 8;
    localparam int NDIG   = (fbdr_pkg::MUL_B_W + DIG_W - 1) / DIG_W;
    localparam int BPAD_W = NDIG * DIG_W;
    localparam int CNT_W  = $clog2(NDIG + 1);
    localparam int PP_W   = fbdr_pkg::MUL_A_W + DIG_W;

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [fbdr_pkg::MUL_A_W-1:0]  r_a;
    logic [BPAD_W-1:0]             r_b;
    logic [fbdr_pkg::PROD_W-1:0]   r_acc;
    logic [PP_W-1:0]               w_pp;
    logic [fbdr_pkg::PROD_W-1:0]   w_acc_n;

    // msb digit first, accumulator shifts up one digit per step
    assign w_pp    = {{DIG_W{1'b0}}, r_a} * {{fbdr_pkg::MUL_A_W{1'b0}}, r_b[BPAD_W-1 -: DIG_W]};
    assign w_acc_n = (r_acc << DIG_W) + fbdr_pkg::PROD_W'(w_pp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(NDIG - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= BPAD_W'(i_b);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= w_acc_n;
            r_b   <= r_b << DIG_W;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ rtl/fbdr_div.sv @@
// bit-serial restoring unit for integer square root and bounded division
module fbdr_div #(
    parameter int DEN_W = 49
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fbdr_pkg::t_div_req            i_req,
    input  logic [fbdr_pkg::NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]              i_den,
    output fbdr_pkg::t_div_rsp            o_rsp,
    output logic [fbdr_pkg::QUO_W-1:0]    o_res
);

    localparam int HI_W  = fbdr_pkg::NUM_W - fbdr_pkg::QUO_W;
    localparam int CS_W  = (DEN_W + 1 > HI_W) ? DEN_W + 1 : HI_W;
    localparam int CNT_W = $clog2(fbdr_pkg::QUO_W + 1);
    localparam int PAD_W = fbdr_pkg::NUM_W - fbdr_pkg::SUM_W;

    typedef enum logic [1:0] {
        D_IDLE,
        D_PRE,
        D_RUN
    } t_dstate;

    t_dstate                       r_state;
    logic                          r_root;
    logic                          r_done;
    logic                          r_ovf;
    logic [CNT_W-1:0]              r_cnt;
    logic [CS_W-1:0]               r_rem;
    logic [fbdr_pkg::NUM_W-1:0]    r_num;
    logic [fbdr_pkg::QUO_W-1:0]    r_res;
    logic [DEN_W-1:0]              r_den;
    logic [CS_W-1:0]               w_cand;
    logic [CS_W-1:0]               w_trial;
    logic [CS_W:0]                 w_diff;
    logic                          w_ge;
    logic [CNT_W-1:0]              w_last_cnt;

    always_comb begin
        priority if (r_state == D_PRE) begin
            w_cand = r_rem;
        end else if (r_root) begin
            w_cand = {r_rem[CS_W-3:0], r_num[fbdr_pkg::NUM_W-1 -: 2]};
        end else begin
            w_cand = {r_rem[CS_W-2:0], r_num[fbdr_pkg::NUM_W-1]};
        end
    end

    // shared trial subtract
    assign w_trial    = r_root ? CS_W'({r_res, 2'b01}) : CS_W'(r_den);
    assign w_diff     = {1'b0, w_cand} - {1'b0, w_trial};
    assign w_ge       = !w_diff[CS_W];
    assign w_last_cnt = r_root ? CNT_W'(fbdr_pkg::DIST_W - 1) : CNT_W'(fbdr_pkg::QUO_W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_root <= i_req.root;
                        r_den  <= i_den;
                        r_res  <= '0;
                        r_cnt  <= '0;
                        r_ovf  <= 1'b0;
                        if (i_req.root) begin
                            r_rem   <= '0;
                            r_num   <= {i_num[fbdr_pkg::SUM_W-1:0], {PAD_W{1'b0}}};
                            r_state <= D_RUN;
                        end else begin
                            r_rem   <= CS_W'(i_num[fbdr_pkg::NUM_W-1 -: HI_W]);
                            r_num   <= {i_num[fbdr_pkg::QUO_W-1:0], {HI_W{1'b0}}};
                            r_state <= D_PRE;
                        end
                    end
                end
                D_PRE: begin
                    // quotient would need more than the result width
                    if (w_ge) begin
                        r_ovf   <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= w_ge ? w_diff[CS_W-1:0] : w_cand;
                    r_res <= {r_res[fbdr_pkg::QUO_W-2:0], w_ge};
                    r_num <= r_root ? (r_num << 2) : (r_num << 1);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == w_last_cnt) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_rsp = '{done: r_done, ovf: r_ovf};
    assign o_res = r_res;

endmodule

@@ rtl/flat_bottom_distance_restraint.sv @@
// flat-bottom harmonic distance restraint: sequencer, energy total and result register
//
//  port group   dir  tdata fields (lsb first)                             side bits
//  i_s_*        in   first_x/y/z, second_x/y/z, rest_length, tolerance,  tlast = last_spring
//                    stiffness
//  o_m_*        out  energy_term, energy_total, force_x/y/z               tuser = zero_distance,
//                                                                         tlast = set_done
//
//  each axis force with a nonzero offset needs a 48-step bit-serial divide,
//  the distance a 33-step root, and each product 5 digit steps of the shared multiplier
//  items with no force (inside tolerance, zero stiffness, coincident atoms) skip the force divides
//  i_rst_n (synchronous, active low) clears the sequencer, the energy total and o_m_tvalid
//  o_s_tready is high only between items; a finished result waits in the output register
//  while the next item is taken, and the sequencer holds at the end if it is still unread
module flat_bottom_distance_restraint #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, rest_length, tolerance, stiffness
    input  logic [fbdr_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // energy_term, energy_total, force_x, force_y, force_z
    output logic [fbdr_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // zero_distance
    output logic                                o_m_tuser,
    output logic                                o_m_tlast
);

    localparam int DEN_W = fbdr_pkg::DIST_W + FRAC_BITS;
    localparam int ESH   = 2 * FRAC_BITS + 1;
    localparam int AX_W  = $clog2(fbdr_pkg::NUM_AXES);
    localparam int NA    = fbdr_pkg::NUM_AXES;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DELTA,
        S_AXIS,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        OP_SQ,
        OP_MAG2,
        OP_ENERGY,
        OP_KM,
        OP_NUM
    } t_op;

    t_state                              r_state;
    t_op                                 r_op;
    logic [AX_W-1:0]                     r_ax;
    logic [fbdr_pkg::ABS_W-1:0]          r_abs [NA];
    logic                                r_neg [NA];
    logic [fbdr_pkg::FORCE_W-1:0]        r_force [NA];
    logic [fbdr_pkg::SUM_W-1:0]          r_sum;
    logic [fbdr_pkg::DIST_W-1:0]         r_d;
    logic [fbdr_pkg::LEN_W-1:0]          r_ln;
    logic [fbdr_pkg::LEN_W-1:0]          r_tol;
    logic [fbdr_pkg::K_W-1:0]            r_k;
    logic                                r_last;
    logic [fbdr_pkg::MAG_W-1:0]          r_mag;
    logic                                r_dneg;
    logic [fbdr_pkg::MUL_A_W-1:0]        r_km;
    logic [fbdr_pkg::ENERGY_W-1:0]       r_term;
    logic [fbdr_pkg::ENERGY_W-1:0]       r_total;
    logic [fbdr_pkg::ENERGY_W-1:0]       r_acc;
    logic                                r_mul_start;
    logic [fbdr_pkg::MUL_A_W-1:0]        r_mul_a;
    logic [fbdr_pkg::MUL_B_W-1:0]        r_mul_b;
    fbdr_pkg::t_div_req                  r_div_req;
    logic [fbdr_pkg::NUM_W-1:0]          r_div_num;
    logic                                r_m_valid;
    logic [fbdr_pkg::OUT_DATA_W-1:0]     r_m_data;
    logic                                r_m_user;
    logic                                r_m_last;

    logic [fbdr_pkg::COORD_W-1:0]        w_fst [NA];
    logic [fbdr_pkg::COORD_W-1:0]        w_sec [NA];
    logic [fbdr_pkg::DIFF_W-1:0]         w_diff [NA];
    logic [fbdr_pkg::ABS_W-1:0]          w_abs [NA];
    logic                                w_mul_done;
    logic [fbdr_pkg::PROD_W-1:0]         w_mul_prod;
    fbdr_pkg::t_div_rsp                  w_div_rsp;
    logic [fbdr_pkg::QUO_W-1:0]          w_div_res;
    logic [DEN_W-1:0]                    w_den;
    logic [fbdr_pkg::SUM_W-1:0]          w_sum_n;
    logic [fbdr_pkg::DIST_W:0]           w_e;
    logic [fbdr_pkg::DIST_W:0]           w_ae;
    logic [fbdr_pkg::MAG_W-1:0]          w_mag;
    logic [fbdr_pkg::PROD_W-1:0]         w_eshift;
    logic                                w_esat;
    logic [fbdr_pkg::ENERGY_W-1:0]       w_term;
    logic [fbdr_pkg::ENERGY_W-1:0]       w_sum64;
    logic [fbdr_pkg::ENERGY_W-1:0]       w_total;
    logic                                w_fneg;
    logic [fbdr_pkg::FORCE_W-1:0]        w_fval;
    logic                                w_last_ax;
    logic                                w_no_force;

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            w_fst[i]  = i_s_tdata[i * fbdr_pkg::COORD_W +: fbdr_pkg::COORD_W];
            w_sec[i]  = i_s_tdata[(NA + i) * fbdr_pkg::COORD_W +: fbdr_pkg::COORD_W];
            w_diff[i] = {w_sec[i][fbdr_pkg::COORD_W-1], w_sec[i]}
                      - {w_fst[i][fbdr_pkg::COORD_W-1], w_fst[i]};
            w_abs[i]  = w_diff[i][fbdr_pkg::DIFF_W-1] ? ('0 - w_diff[i]) : w_diff[i];
        end
    end

    assign w_sum_n = r_sum + w_mul_prod[fbdr_pkg::SUM_W-1:0];
    assign w_den   = {r_d, {FRAC_BITS{1'b0}}};

    // signed excess over the flat bottom
    assign w_e   = {1'b0, r_d} - (fbdr_pkg::DIST_W + 1)'(r_ln);
    assign w_ae  = w_e[fbdr_pkg::DIST_W] ? ('0 - w_e) : w_e;
    assign w_mag = (w_ae > (fbdr_pkg::DIST_W + 1)'(r_tol))
                 ? fbdr_pkg::MAG_W'(w_ae - (fbdr_pkg::DIST_W + 1)'(r_tol)) : '0;

    // energy term and saturating total
    assign w_eshift = w_mul_prod >> ESH;
    assign w_esat   = |w_eshift[fbdr_pkg::PROD_W-1:fbdr_pkg::ENERGY_W-1];
    assign w_term   = w_esat ? fbdr_pkg::ENERGY_MAX
                             : {1'b0, w_eshift[fbdr_pkg::ENERGY_W-2:0]};
    assign w_sum64  = r_acc + w_term;
    assign w_total  = w_sum64[fbdr_pkg::ENERGY_W-1] ? fbdr_pkg::ENERGY_MAX : w_sum64;

    // signed, saturated force from the quotient
    assign w_fneg = r_dneg ^ r_neg[0];
    always_comb begin
        if (w_fneg) begin
            w_fval = (w_div_rsp.ovf || (w_div_res[fbdr_pkg::QUO_W-1] && |w_div_res[fbdr_pkg::QUO_W-2:0]))
                   ? fbdr_pkg::FORCE_NEG_MAX : fbdr_pkg::FORCE_W'('0 - w_div_res);
        end else begin
            w_fval = (w_div_rsp.ovf || w_div_res[fbdr_pkg::QUO_W-1])
                   ? fbdr_pkg::FORCE_POS_MAX : fbdr_pkg::FORCE_W'(w_div_res);
        end
    end

    assign w_last_ax  = (r_ax == AX_W'(NA - 1));
    assign w_no_force = (r_d == '0) || (r_mag == '0) || (r_k == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_start <= 1'b0;
            r_div_req   <= '{start: 1'b0, root: 1'b0};
            r_m_valid   <= 1'b0;
            r_acc       <= '0;
        end else begin
            r_mul_start     <= 1'b0;
            r_div_req.start <= 1'b0;
            if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        for (int i = 0; i < NA; i++) begin
                            r_abs[i] <= w_abs[i];
                            r_neg[i] <= w_diff[i][fbdr_pkg::DIFF_W-1];
                        end
                        r_ln        <= i_s_tdata[fbdr_pkg::LN_LSB +: fbdr_pkg::LEN_W];
                        r_tol       <= i_s_tdata[fbdr_pkg::TOL_LSB +: fbdr_pkg::LEN_W];
                        r_k         <= i_s_tdata[fbdr_pkg::K_LSB +: fbdr_pkg::K_W];
                        r_last      <= i_s_tlast;
                        r_sum       <= '0;
                        r_ax        <= '0;
                        r_mul_start <= 1'b1;
                        r_mul_a     <= fbdr_pkg::MUL_A_W'(w_abs[0]);
                        r_mul_b     <= w_abs[0];
                        r_op        <= OP_SQ;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        unique case (r_op)
                            OP_SQ: begin
                                r_sum    <= w_sum_n;
                                r_abs[0] <= r_abs[1];
                                r_abs[1] <= r_abs[2];
                                r_abs[2] <= r_abs[0];
                                r_neg[0] <= r_neg[1];
                                r_neg[1] <= r_neg[2];
                                r_neg[2] <= r_neg[0];
                                if (w_last_ax) begin
                                    r_div_req <= '{start: 1'b1, root: 1'b1};
                                    r_div_num <= fbdr_pkg::NUM_W'(w_sum_n);
                                    r_state   <= S_DIV;
                                end else begin
                                    r_ax        <= r_ax + 1'b1;
                                    r_mul_start <= 1'b1;
                                    r_mul_a     <= fbdr_pkg::MUL_A_W'(r_abs[1]);
                                    r_mul_b     <= r_abs[1];
                                end
                            end
                            OP_MAG2: begin
                                r_mul_start <= 1'b1;
                                r_mul_a     <= w_mul_prod[fbdr_pkg::MUL_A_W-1:0];
                                r_mul_b     <= fbdr_pkg::MUL_B_W'(r_k);
                                r_op        <= OP_ENERGY;
                            end
                            OP_ENERGY: begin
                                r_term  <= w_term;
                                r_total <= w_total;
                                r_acc   <= r_last ? '0 : w_total;
                                if (w_no_force) begin
                                    for (int i = 0; i < NA; i++) begin
                                        r_force[i] <= '0;
                                    end
                                    r_state <= S_FIN;
                                end else begin
                                    r_mul_start <= 1'b1;
                                    r_mul_a     <= fbdr_pkg::MUL_A_W'(r_k);
                                    r_mul_b     <= fbdr_pkg::MUL_B_W'(r_mag);
                                    r_op        <= OP_KM;
                                end
                            end
                            OP_KM: begin
                                r_km    <= w_mul_prod[fbdr_pkg::MUL_A_W-1:0];
                                r_ax    <= '0;
                                r_state <= S_AXIS;
                            end
                            OP_NUM: begin
                                r_div_req <= '{start: 1'b1, root: 1'b0};
                                r_div_num <= w_mul_prod[fbdr_pkg::NUM_W-1:0];
                                r_state   <= S_DIV;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        if (r_op == OP_SQ) begin
                            r_d     <= w_div_res[fbdr_pkg::DIST_W-1:0];
                            r_state <= S_DELTA;
                        end else begin
                            r_force[0] <= r_force[1];
                            r_force[1] <= r_force[2];
                            r_force[2] <= w_fval;
                            r_abs[0]   <= r_abs[1];
                            r_abs[1]   <= r_abs[2];
                            r_abs[2]   <= r_abs[0];
                            r_neg[0]   <= r_neg[1];
                            r_neg[1]   <= r_neg[2];
                            r_neg[2]   <= r_neg[0];
                            r_ax       <= r_ax + 1'b1;
                            r_state    <= w_last_ax ? S_FIN : S_AXIS;
                        end
                    end
                end
                S_DELTA: begin
                    r_mag       <= w_mag;
                    r_dneg      <= w_e[fbdr_pkg::DIST_W];
                    r_mul_start <= 1'b1;
                    r_mul_a     <= fbdr_pkg::MUL_A_W'(w_mag);
                    r_mul_b     <= fbdr_pkg::MUL_B_W'(w_mag);
                    r_op        <= OP_MAG2;
                    r_state     <= S_MUL;
                end
                S_AXIS: begin
                    if (r_abs[0] == '0) begin
                        // no offset on this axis
                        r_force[0] <= r_force[1];
                        r_force[1] <= r_force[2];
                        r_force[2] <= '0;
                        r_abs[0]   <= r_abs[1];
                        r_abs[1]   <= r_abs[2];
                        r_abs[2]   <= r_abs[0];
                        r_neg[0]   <= r_neg[1];
                        r_neg[1]   <= r_neg[2];
                        r_neg[2]   <= r_neg[0];
                        r_ax       <= r_ax + 1'b1;
                        r_state    <= w_last_ax ? S_FIN : S_AXIS;
                    end else begin
                        r_mul_start <= 1'b1;
                        r_mul_a     <= r_km;
                        r_mul_b     <= r_abs[0];
                        r_op        <= OP_NUM;
                        r_state     <= S_MUL;
                    end
                end
                S_FIN: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {r_force[2], r_force[1], r_force[0], r_total, r_term};
                        r_m_user  <= (r_d == '0);
                        r_m_last  <= r_last;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    fbdr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    fbdr_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .i_num   (r_div_num),
        .i_den   (w_den),
        .o_rsp   (w_div_rsp),
        .o_res   (w_div_res)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

`ifndef SYNTHESIS
    a_mul_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> r_state == S_MUL)
        else $error("multiplier finished outside a multiply step");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside a divide step");

    a_zero_dist_no_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser
            |-> r_m_data[fbdr_pkg::OUT_DATA_W-1:2*fbdr_pkg::ENERGY_W] == '0)
        else $error("force reported for coincident atoms");

    a_total_covers_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_m_data[2*fbdr_pkg::ENERGY_W-1:fbdr_pkg::ENERGY_W]
                       >= r_m_data[fbdr_pkg::ENERGY_W-1:0])
        else $error("energy total below energy term");

    a_set_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && r_last |-> r_acc == '0)
        else $error("energy total not cleared after last spring");
`endif

endmodule
